@@ hdl/i2cra_pkg.sv @@
// Package for the I2C register access master: phase and stage codes, commands, sizes.
// No dependencies.
`timescale 1ns / 1ps
package i2cra_pkg;
	localparam int WRITE_DEPTH = 16;
	localparam int WA = (WRITE_DEPTH > 1) ? $clog2(WRITE_DEPTH) : 1;
	localparam int WC = $clog2(WRITE_DEPTH + 1);

	typedef enum logic [1:0] {
		CMD_TICK = 2'd0, CMD_PUSH = 2'd1, CMD_WRITE = 2'd2, CMD_READ = 2'd3
	} cmd_t;

	typedef enum logic [3:0] {
		P_IDLE, P_ST1, P_ST2, P_TX_LO, P_TX_HI, P_TX_TAIL, P_AK_REL, P_AK_HI,
		P_AK_POLL, P_RX_LO, P_RX_HI, P_RA_LO, P_RA_HI, P_SP1, P_SP2, P_SP3
	} phase_t;

	typedef enum logic [1:0] { S_DEV, S_REG, S_DATA, S_RDEV } stage_t;

	typedef struct packed {
		logic [1:0]  cmd;
		logic        bus_sel;
		logic [7:0]  dev_addr;
		logic [7:0]  reg_addr;
		logic [15:0] read_len;
		logic [7:0]  wr_byte;
		logic        sda_in;
	} req_t;

	typedef struct packed {
		logic [5:0] lines;
		logic       busy;
		logic       done;
		logic       status;
		logic [7:0] rx_byte;
		logic       rx_valid;
		logic       rx_last;
	} res_t;
endpackage

@@ hdl/i2cra_core.sv @@
// Sequencer core for the I2C register access master: one request per cycle.
// Depends on i2cra_pkg.
`timescale 1ns / 1ps
module i2cra_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	input  i2cra_pkg::req_t  req,
	input  logic [7:0]       ack_timeout,
	output i2cra_pkg::res_t  res
);
	import i2cra_pkg::*;

	phase_t      phase_q, phase_d;
	logic [2:0]  pt_q, pt_d;
	logic [3:0]  bit_q, bit_d;
	logic [7:0]  sh_q, sh_d;
	logic [7:0]  wait_q, wait_d;
	logic [15:0] left_q, left_d;
	logic [WC-1:0] cnt_q, cnt_d;
	logic [7:0]  dev_q, dev_d, reg_q, reg_d;
	logic        bus_q, bus_d;
	logic [5:0]  lv_q, lv_d;
	logic        fail_q, fail_d, rd_q, rd_d;
	stage_t      stg_q, stg_d;
	logic [7:0]  buf_q [WRITE_DEPTH];
	logic        wr_en;
	logic        done, rxn, rxe;
	logic [15:0] idx;
	logic [7:0]  bufb;

	function automatic logic [2:0] lv_sel(input logic [5:0] l, input logic b);
		return b ? l[5:3] : l[2:0];
	endfunction

	assign idx  = {{(16 - WC){1'b0}}, cnt_q} - left_q;
	assign bufb = (idx < 16'(WRITE_DEPTH)) ? buf_q[idx[WA-1:0]] : 8'd0;
	assign wr_en = req_valid && req.cmd == CMD_PUSH && phase_q == P_IDLE
		&& cnt_q < WC'(WRITE_DEPTH);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			buf_q[cnt_q[WA-1:0]] <= req.wr_byte;
		end
	end

	always_comb begin
		logic [2:0] v;
		logic tx_b, ack_ok, go_stop, go_rx, go_byte, go_start;
		logic [7:0] nb;
		phase_d = phase_q; pt_d = pt_q; bit_d = bit_q; sh_d = sh_q;
		wait_d = wait_q; left_d = left_q; cnt_d = cnt_q; dev_d = dev_q;
		reg_d = reg_q; bus_d = bus_q; fail_d = fail_q; rd_d = rd_q;
		stg_d = stg_q; done = 1'b0; rxn = 1'b0; rxe = 1'b0;
		v = lv_sel(lv_q, bus_q); ack_ok = 1'b0; go_stop = 1'b0; go_rx = 1'b0;
		go_byte = 1'b0; go_start = 1'b0; nb = 8'd0;
		tx_b = sh_q[7];
		if (req_valid) begin
			if (req.cmd != CMD_TICK) begin
				if (phase_q == P_IDLE) begin
					if (req.cmd == CMD_PUSH) begin
						if (wr_en) begin
							cnt_d = cnt_q + 1'b1;
						end
					end else begin
						bus_d = req.bus_sel; dev_d = req.dev_addr;
						reg_d = req.reg_addr; rd_d = (req.cmd == CMD_READ);
						fail_d = 1'b0; stg_d = S_DEV;
						if (req.cmd == CMD_READ) begin
							left_d = (req.read_len == 16'd0) ? 16'd1 : req.read_len;
						end else begin
							left_d = {{(16 - WC){1'b0}}, cnt_q};
						end
						sh_d = req.dev_addr;
						go_start = 1'b1;
					end
				end
			end else if (phase_q == P_AK_POLL) begin
				if (!req.sda_in) begin
					v = 3'b010; ack_ok = 1'b1;
				end else if (wait_q >= ack_timeout) begin
					fail_d = 1'b1; go_stop = 1'b1;
				end else begin
					wait_d = wait_q + 8'd1;
				end
			end else if (phase_q != P_IDLE) begin
				if (pt_q > 3'd1) begin
					pt_d = pt_q - 3'd1;
				end else begin
					pt_d = 3'd0;
					case (phase_q)
						P_ST1: begin v = 3'b101; phase_d = P_ST2; pt_d = 3'd4; end
						P_ST2: begin nb = sh_q; go_byte = 1'b1; end
						P_TX_LO: begin v = {1'b1, tx_b, 1'b1}; phase_d = P_TX_HI; pt_d = 3'd2; end
						P_TX_HI: begin v = {1'b1, tx_b, 1'b0}; phase_d = P_TX_TAIL; pt_d = 3'd2; end
						P_TX_TAIL: begin
							bit_d = bit_q + 4'd1;
							sh_d = {sh_q[6:0], 1'b0};
							if (bit_q + 4'd1 < 4'd8) begin
								v = {1'b1, sh_q[6], 1'b0}; phase_d = P_TX_LO; pt_d = 3'd2;
							end else begin
								v = 3'b010; phase_d = P_AK_REL; pt_d = 3'd1;
							end
						end
						P_AK_REL: begin v = 3'b011; phase_d = P_AK_HI; pt_d = 3'd1; end
						P_AK_HI: begin v = lv_sel(lv_q, bus_q); wait_d = 8'd0; phase_d = P_AK_POLL; end
						P_RX_LO: begin
							sh_d = {sh_q[6:0], req.sda_in};
							bit_d = bit_q + 4'd1;
							v = 3'b011;
							if (bit_q + 4'd1 == 4'd8) begin
								rxn = 1'b1; rxe = (left_q <= 16'd1);
							end
							phase_d = P_RX_HI; pt_d = 3'd1;
						end
						P_RX_HI: begin
							if (bit_q < 4'd8) begin
								v = 3'b010; phase_d = P_RX_LO; pt_d = 3'd2;
							end else begin
								v = {1'b1, left_q <= 16'd1, 1'b0}; phase_d = P_RA_LO; pt_d = 3'd2;
							end
						end
						P_RA_LO: begin v = {1'b1, left_q <= 16'd1, 1'b1}; phase_d = P_RA_HI; pt_d = 3'd2; end
						P_RA_HI: begin
							v = lv_sel(lv_q, bus_q);
							if (left_q > 16'd1) begin
								left_d = left_q - 16'd1; go_rx = 1'b1;
							end else begin
								left_d = 16'd0; go_stop = 1'b1;
							end
						end
						P_SP1: begin v = 3'b101; phase_d = P_SP2; pt_d = 3'd2; end
						P_SP2: begin v = 3'b111; phase_d = P_SP3; pt_d = 3'd4; end
						P_SP3: begin
							v = lv_sel(lv_q, bus_q);
							done = 1'b1;
							if (!rd_q) begin
								cnt_d = '0;
							end
							phase_d = P_IDLE;
						end
						default: begin v = lv_sel(lv_q, bus_q); phase_d = P_IDLE; end
					endcase
				end
			end
		end
		if (ack_ok) begin
			case (stg_q)
				S_DEV: begin stg_d = S_REG; nb = reg_q; go_byte = 1'b1; end
				S_REG: begin
					if (rd_q) begin
						stg_d = S_RDEV; sh_d = dev_q + 8'd1; go_start = 1'b1;
					end else if (left_q != 16'd0 && {{(16 - WC){1'b0}}, cnt_q} >= left_q) begin
						stg_d = S_DATA; nb = bufb; go_byte = 1'b1;
					end else begin
						go_stop = 1'b1;
					end
				end
				S_DATA: begin
					if (left_q != 16'd0) begin
						left_d = left_q - 16'd1;
					end
					if (left_d != 16'd0 && {{(16 - WC){1'b0}}, cnt_q} >= left_d) begin
						stg_d = S_DATA;
						nb = buf_q[WA'({{(16 - WC){1'b0}}, cnt_q} - left_d)];
						go_byte = 1'b1;
					end else begin
						go_stop = 1'b1;
					end
				end
				default: go_rx = 1'b1;
			endcase
		end
		if (go_byte) begin
			sh_d = nb; bit_d = 4'd0; wait_d = 8'd0;
			v = {1'b1, nb[7], 1'b0}; phase_d = P_TX_LO; pt_d = 3'd2;
		end
		if (go_start) begin
			v = 3'b111; phase_d = P_ST1; pt_d = 3'd4;
		end
		if (go_stop) begin
			v = 3'b100; phase_d = P_SP1; pt_d = 3'd4;
		end
		if (go_rx) begin
			sh_d = 8'd0; bit_d = 4'd0;
			v = 3'b010; phase_d = P_RX_LO; pt_d = 3'd2;
		end
		lv_d = bus_d ? {v, lv_q[2:0]} : {lv_q[5:3], v};
		if (!req_valid) begin
			lv_d = lv_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= P_IDLE; pt_q <= '0; bit_q <= '0; sh_q <= '0; wait_q <= '0;
			left_q <= '0; cnt_q <= '0; dev_q <= '0; reg_q <= '0; bus_q <= 1'b0;
			lv_q <= 6'h3F; fail_q <= 1'b0; rd_q <= 1'b0; stg_q <= S_DEV;
			res <= '0;
		end else if (req_valid) begin
			phase_q <= phase_d; pt_q <= pt_d; bit_q <= bit_d; sh_q <= sh_d;
			wait_q <= wait_d; left_q <= left_d; cnt_q <= cnt_d; dev_q <= dev_d;
			reg_q <= reg_d; bus_q <= bus_d; lv_q <= lv_d; fail_q <= fail_d;
			rd_q <= rd_d; stg_q <= stg_d;
			res.lines    <= lv_d;
			res.busy     <= (phase_d != P_IDLE);
			res.done     <= done;
			res.status   <= done & fail_d;
			res.rx_byte  <= rxn ? sh_d : 8'd0;
			res.rx_valid <= rxn;
			res.rx_last  <= rxn & rxe;
		end
	end
endmodule

@@ hdl/i2c_register_access_master.sv @@
// Latency: a request's result is registered in the core's result register before it reaches the outputs.
// Throughput: one request per cycle while in_stall is low; the result register and a one-entry skid stage
// decouple the two channels.
// Reset: asynchronous, active low; line state high and driven (outputs read zero until the first result),
// sequencer idle, ack_timeout 250, write buffer contents undefined until pushed.
// Depends on i2cra_pkg and i2cra_core.
`timescale 1ns / 1ps
module i2c_register_access_master (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  cmd,
	input  logic        bus_sel,
	input  logic [7:0]  dev_addr,
	input  logic [7:0]  reg_addr,
	input  logic [15:0] read_len,
	input  logic [7:0]  wr_byte,
	input  logic        sda_in,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        scl_a,
	output logic        sda_a,
	output logic        sda_a_drive,
	output logic        scl_b,
	output logic        sda_b,
	output logic        sda_b_drive,
	output logic        busy_res,
	output logic        done_res,
	output logic        status,
	output logic [7:0]  rx_byte,
	output logic        rx_valid,
	output logic        rx_last
);
	import i2cra_pkg::*;

	logic [7:0] tmo_q;
	req_t       req;
	res_t       res, skid_q, cur;
	logic       acc, v_q, skv_q;

	assign req = '{cmd: cmd, bus_sel: bus_sel, dev_addr: dev_addr, reg_addr: reg_addr,
		read_len: read_len, wr_byte: wr_byte, sda_in: sda_in};
	assign in_stall = skv_q;
	assign acc = in_valid && !skv_q;

	i2cra_core u_core (
		.clk(clk), .arst_n(arst_n), .req_valid(acc), .req(req),
		.ack_timeout(tmo_q), .res(res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tmo_q <= 8'd250; v_q <= 1'b0; skv_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				tmo_q <= cfg_wdata;
			end
			if (skv_q) begin
				if (!out_stall) begin
					skv_q <= 1'b0;
				end
				v_q <= 1'b1;
			end else begin
				if (v_q && out_stall && acc) begin
					skv_q <= 1'b1;
				end
				if (acc) begin
					v_q <= 1'b1;
				end else if (!out_stall) begin
					v_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!skv_q && v_q && out_stall && acc) begin
			skid_q <= res;
		end
	end

	logic       hold_q;
	res_t       out_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q <= 1'b0;
			out_q  <= '0;
		end else begin
			if (v_q && out_stall) begin
				hold_q <= 1'b1;
				if (!hold_q) begin
					out_q <= res;
				end
			end else if (skv_q && !out_stall) begin
				hold_q <= 1'b0;
			end else begin
				hold_q <= 1'b0;
			end
		end
	end

	always_comb begin
		if (skv_q && !hold_q) begin
			cur = skid_q;
		end else if (hold_q) begin
			cur = out_q;
		end else begin
			cur = res;
		end
	end

	assign out_valid   = v_q;
	assign scl_a       = cur.lines[0];
	assign sda_a       = cur.lines[1];
	assign sda_a_drive = cur.lines[2];
	assign scl_b       = cur.lines[3];
	assign sda_b       = cur.lines[4];
	assign sda_b_drive = cur.lines[5];
	assign busy_res    = cur.busy;
	assign done_res    = cur.done;
	assign status      = cur.status;
	assign rx_byte     = cur.rx_byte;
	assign rx_valid    = cur.rx_valid;
	assign rx_last     = cur.rx_last;
endmodule

@@ verif/i2c_register_access_master_tb.sv @@
// Testbench for the I2C register access master: predicts every request's line levels,
// status and received bytes, and checks them against the block under random flow control.
// Depends on i2cra_pkg and i2c_register_access_master.
`timescale 1ns / 1ps
module i2c_register_access_master_tb;
	import i2cra_pkg::*;

	typedef struct packed {
		logic [5:0] lines;
		logic       busy;
		logic       done;
		logic       status;
		logic [7:0] rx_byte;
		logic       rx_valid;
		logic       rx_last;
	} bus_view_t;

	typedef struct {
		bit          is_cfg;
		logic [7:0]  cfg;
		logic [1:0]  cmd;
		logic        bus_sel;
		logic [7:0]  dev_addr;
		logic [7:0]  reg_addr;
		logic [15:0] read_len;
		logic [7:0]  wr_byte;
		logic        sda_in;
	} job_t;

	logic clk = 0, arst_n = 0;
	logic cfg_we = 0;
	logic [7:0] cfg_wdata = 0;
	logic in_valid = 0, in_stall, out_valid, out_stall = 0;
	logic [1:0] cmd = 0;
	logic bus_sel = 0, sda_in = 0;
	logic [7:0] dev_addr = 0, reg_addr = 0, wr_byte = 0;
	logic [15:0] read_len = 0;
	logic scl_a, sda_a, sda_a_drive, scl_b, sda_b, sda_b_drive;
	logic busy_res, done_res, status, rx_last, rx_valid;
	logic [7:0] rx_byte;

	i2c_register_access_master uut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_stall(in_stall), .cmd(cmd), .bus_sel(bus_sel),
		.dev_addr(dev_addr), .reg_addr(reg_addr), .read_len(read_len),
		.wr_byte(wr_byte), .sda_in(sda_in), .out_valid(out_valid),
		.out_stall(out_stall), .scl_a(scl_a), .sda_a(sda_a),
		.sda_a_drive(sda_a_drive), .scl_b(scl_b), .sda_b(sda_b),
		.sda_b_drive(sda_b_drive), .busy_res(busy_res), .done_res(done_res),
		.status(status), .rx_byte(rx_byte), .rx_valid(rx_valid), .rx_last(rx_last)
	);

	always #10 clk = ~clk;

	// predictor state
	logic [7:0]  m_timeout;
	phase_t      m_phase;
	logic [2:0]  m_ticks;
	logic [3:0]  m_bit;
	logic [7:0]  m_shift, m_wait;
	logic [15:0] m_left;
	logic [7:0]  m_buf [WRITE_DEPTH];
	logic [4:0]  m_count;
	logic [7:0]  m_dev, m_reg;
	logic        m_bus;
	logic [5:0]  m_lines;
	bit          m_failed, m_read, m_done, m_rx, m_rxend;
	stage_t      m_stage;

	job_t pending[$];
	bus_view_t expected_views[$];
	int errors = 0;
	int cycles = 0;
	bit stim_done = 0;

	function automatic void set_lines(input logic scl, input logic sda, input logic drv);
		if (m_bus) m_lines[5:3] = {drv, sda, scl};
		else m_lines[2:0] = {drv, sda, scl};
	endfunction

	function automatic void go_phase(input phase_t p, input int d);
		m_phase = p;
		m_ticks = 3'(d);
	endfunction

	function automatic void send_byte(input logic [7:0] b);
		m_shift = b;
		m_bit = 0;
		m_wait = 0;
		set_lines(1'b0, b[7], 1'b1);
		go_phase(P_TX_LO, 2);
	endfunction

	function automatic void send_stop();
		set_lines(1'b0, 1'b0, 1'b1);
		go_phase(P_SP1, 4);
	endfunction

	function automatic void send_start();
		set_lines(1'b1, 1'b1, 1'b1);
		go_phase(P_ST1, 4);
	endfunction

	function automatic void recv_byte();
		m_shift = 0;
		m_bit = 0;
		set_lines(1'b0, 1'b1, 1'b0);
		go_phase(P_RX_LO, 2);
	endfunction

	function automatic void data_or_stop();
		logic [15:0] idx;
		if (m_left != 0 && {11'd0, m_count} >= m_left) begin
			idx = {11'd0, m_count} - m_left;
			m_stage = S_DATA;
			send_byte(idx < WRITE_DEPTH ? m_buf[idx[WA-1:0]] : 8'h00);
		end else begin
			send_stop();
		end
	endfunction

	function automatic void acked();
		case (m_stage)
			S_DEV: begin
				m_stage = S_REG;
				send_byte(m_reg);
			end
			S_REG: begin
				if (m_read) begin
					m_stage = S_RDEV;
					m_shift = m_dev + 8'd1;
					send_start();
				end else begin
					data_or_stop();
				end
			end
			S_DATA: begin
				if (m_left != 0) m_left--;
				data_or_stop();
			end
			default: recv_byte();
		endcase
	endfunction

	function automatic void phase_end(input logic sda);
		case (m_phase)
			P_ST1: begin
				set_lines(1'b1, 1'b0, 1'b1);
				go_phase(P_ST2, 4);
			end
			P_ST2: begin
				set_lines(1'b0, 1'b0, 1'b1);
				send_byte(m_shift);
			end
			P_TX_LO: begin
				set_lines(1'b1, m_shift[7], 1'b1);
				go_phase(P_TX_HI, 2);
			end
			P_TX_HI: begin
				set_lines(1'b0, m_shift[7], 1'b1);
				go_phase(P_TX_TAIL, 2);
			end
			P_TX_TAIL: begin
				m_bit++;
				m_shift = m_shift << 1;
				if (m_bit < 8) begin
					set_lines(1'b0, m_shift[7], 1'b1);
					go_phase(P_TX_LO, 2);
				end else begin
					set_lines(1'b0, 1'b1, 1'b0);
					go_phase(P_AK_REL, 1);
				end
			end
			P_AK_REL: begin
				set_lines(1'b1, 1'b1, 1'b0);
				go_phase(P_AK_HI, 1);
			end
			P_AK_HI: begin
				m_wait = 0;
				go_phase(P_AK_POLL, 0);
			end
			P_RX_LO: begin
				m_shift = {m_shift[6:0], sda};
				m_bit++;
				set_lines(1'b1, 1'b1, 1'b0);
				if (m_bit == 8) begin
					m_rx = 1;
					m_rxend = (m_left <= 1);
				end
				go_phase(P_RX_HI, 1);
			end
			P_RX_HI: begin
				if (m_bit < 8) begin
					set_lines(1'b0, 1'b1, 1'b0);
					go_phase(P_RX_LO, 2);
				end else begin
					set_lines(1'b0, m_left <= 1, 1'b1);
					go_phase(P_RA_LO, 2);
				end
			end
			P_RA_LO: begin
				set_lines(1'b1, m_left <= 1, 1'b1);
				go_phase(P_RA_HI, 2);
			end
			P_RA_HI: begin
				if (m_left != 0) m_left--;
				if (m_left != 0) recv_byte();
				else send_stop();
			end
			P_SP1: begin
				set_lines(1'b1, 1'b0, 1'b1);
				go_phase(P_SP2, 2);
			end
			P_SP2: begin
				set_lines(1'b1, 1'b1, 1'b1);
				go_phase(P_SP3, 4);
			end
			P_SP3: begin
				m_done = 1;
				if (!m_read) m_count = 0;
				go_phase(P_IDLE, 0);
			end
			default: go_phase(P_IDLE, 0);
		endcase
	endfunction

	task automatic bus_reset();
		m_timeout = 250;
		m_phase = P_IDLE;
		m_ticks = 0;
		m_bit = 0;
		m_shift = 0;
		m_wait = 0;
		m_left = 0;
		m_count = 0;
		m_dev = 0;
		m_reg = 0;
		m_bus = 0;
		m_lines = 6'h3F;
		m_failed = 0;
		m_read = 0;
		m_stage = S_DEV;
	endtask

	function automatic bus_view_t predict_bus(input job_t j);
		bus_view_t v;
		m_done = 0;
		m_rx = 0;
		m_rxend = 0;
		if (j.cmd == CMD_TICK) begin
			if (m_phase == P_AK_POLL) begin
				if (!j.sda_in) begin
					set_lines(1'b0, 1'b1, 1'b0);
					acked();
				end else if (m_wait >= m_timeout) begin
					m_failed = 1;
					send_stop();
				end else begin
					m_wait++;
				end
			end else if (m_phase != P_IDLE) begin
				if (m_ticks > 1) m_ticks--;
				else begin
					m_ticks = 0;
					phase_end(j.sda_in);
				end
			end
		end else if (m_phase == P_IDLE) begin
			if (j.cmd == CMD_PUSH) begin
				if (m_count < WRITE_DEPTH) begin
					m_buf[m_count[WA-1:0]] = j.wr_byte;
					m_count++;
				end
			end else begin
				m_bus = j.bus_sel;
				m_dev = j.dev_addr;
				m_reg = j.reg_addr;
				m_read = (j.cmd == CMD_READ);
				m_failed = 0;
				m_stage = S_DEV;
				if (m_read) m_left = (j.read_len == 0) ? 16'd1 : j.read_len;
				else m_left = {11'd0, m_count};
				m_shift = m_dev;
				send_start();
			end
		end
		v.lines = m_lines;
		v.busy = (m_phase != P_IDLE);
		v.done = m_done;
		v.status = m_done && m_failed;
		v.rx_byte = m_rx ? m_shift : 8'h00;
		v.rx_valid = m_rx;
		v.rx_last = m_rx && m_rxend;
		return v;
	endfunction

	task automatic report(input string what, input bus_view_t got, input bus_view_t want);
		errors++;
		$display("mismatch %s: got %h expected %h at cycle %0d", what, got, want, cycles);
	endtask

	// driver: bursts and gaps; config entries only go out with the pipe drained
	int burst = 0, gap = 0;
	always @(posedge clk) begin
		bit do_cfg;
		do_cfg = 0;
		cycles <= cycles + 1;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				expected_views.push_back(predict_bus(pending.pop_front()));
			end
			if (in_valid && in_stall) begin
				// hold
			end else if (pending.size() != 0 && pending[0].is_cfg) begin
				in_valid <= 0;
				if (!(in_valid && !in_stall) && expected_views.size() == 0 && !out_valid
						&& gap == 0) begin
					do_cfg = 1;
					cfg_wdata <= pending[0].cfg;
					m_timeout = pending[0].cfg;
					void'(pending.pop_front());
					gap <= 3;
				end else if (gap > 0) gap <= gap - 1;
			end else if (gap > 0) begin
				in_valid <= 0;
				gap <= gap - 1;
			end else if (pending.size() != 0 && !pending[0].is_cfg) begin
				in_valid <= 1;
				cmd <= pending[0].cmd;
				bus_sel <= pending[0].bus_sel;
				dev_addr <= pending[0].dev_addr;
				reg_addr <= pending[0].reg_addr;
				read_len <= pending[0].read_len;
				wr_byte <= pending[0].wr_byte;
				sda_in <= pending[0].sda_in;
				if (burst > 0) burst <= burst - 1;
				else begin
					burst <= $urandom_range(0, 40);
					gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 4);
				end
			end else begin
				in_valid <= 0;
			end
		end
		cfg_we <= do_cfg;
	end

	// monitor with its own stall pattern
	int stall_phase = 0;
	always @(posedge clk) begin
		bus_view_t got;
		bus_view_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				got = '0;
				got.lines = {sda_b_drive, sda_b, scl_b, sda_a_drive, sda_a, scl_a};
				got.busy = busy_res;
				got.done = done_res;
				got.status = status;
				got.rx_byte = rx_byte;
				got.rx_valid = rx_valid;
				got.rx_last = rx_last;
				if (expected_views.size() == 0) report("unexpected result", got, '0);
				else begin
					want = expected_views.pop_front();
					if (got.lines !== want.lines) report("lines", got, want);
					if (got.busy !== want.busy) report("busy", got, want);
					if (got.done !== want.done) report("done", got, want);
					if (got.status !== want.status) report("status", got, want);
					if (got.rx_byte !== want.rx_byte) report("rx_byte", got, want);
					if (got.rx_valid !== want.rx_valid) report("rx_valid", got, want);
					if (got.rx_last !== want.rx_last) report("rx_last", got, want);
				end
			end
			stall_phase <= (stall_phase + 1) % 64;
			if (stall_phase < 20) out_stall <= 0;
			else out_stall <= ($urandom_range(0, 3) == 0);
		end
	end

	function automatic job_t mk(input logic [1:0] c);
		job_t j;
		j.is_cfg = 0;
		j.cfg = 0;
		j.cmd = c;
		j.bus_sel = 1'($urandom_range(0, 1));
		j.dev_addr = 8'($urandom_range(0, 255));
		j.reg_addr = 8'($urandom_range(0, 255));
		j.read_len = 16'($urandom_range(1, 3));
		j.wr_byte = 8'($urandom_range(0, 255));
		j.sda_in = 1'($urandom_range(0, 1));
		return j;
	endfunction

	task automatic add_cfg(input logic [7:0] v);
		job_t j;
		j = mk(CMD_TICK);
		j.is_cfg = 1;
		j.cfg = v;
		pending.push_back(j);
	endtask

	// ticks: ack polls get low with probability set by ack_lo (percent)
	task automatic add_ticks(input int n, input int ack_lo);
		job_t j;
		for (int i = 0; i < n; i++) begin
			j = mk(CMD_TICK);
			if ($urandom_range(0, 99) < ack_lo) j.sda_in = 0;
			else if (ack_lo < 100) j.sda_in = 1'($urandom_range(0, 1));
			pending.push_back(j);
		end
	endtask

	task automatic add_txn(input bit rd, input int pushes, input int len);
		job_t j;
		for (int i = 0; i < pushes; i++) pending.push_back(mk(CMD_PUSH));
		j = mk(rd ? CMD_READ : CMD_WRITE);
		j.read_len = 16'(len);
		pending.push_back(j);
	endtask

	initial begin
		job_t j;
		bus_reset();
		repeat (6) @(posedge clk);
		arst_n <= 1;
		// directed: extremes, overflowing push, empty write, zero-length read, timeouts
		add_cfg(8'd1);
		j = mk(CMD_PUSH);
		j.wr_byte = 8'hFF;
		pending.push_back(j);
		j.wr_byte = 8'h00;
		pending.push_back(j);
		j = mk(CMD_WRITE);
		j.dev_addr = 8'hFF;
		j.reg_addr = 8'h00;
		j.bus_sel = 1;
		pending.push_back(j);
		pending.push_back(mk(CMD_PUSH));
		add_ticks(230, 100);
		j = mk(CMD_READ);
		j.read_len = 16'h0000;
		j.dev_addr = 8'h00;
		j.reg_addr = 8'hFF;
		pending.push_back(j);
		add_ticks(220, 60);
		j = mk(CMD_WRITE);
		pending.push_back(j);
		add_ticks(130, 0);
		add_cfg(8'd255);
		add_txn(0, 17, 1);
		add_ticks(200, 100);
		add_cfg(8'd2);
		add_ticks(150, 0);
		add_txn(1, 0, 2);
		add_ticks(260, 97);
		j = mk(CMD_READ);
		j.read_len = 16'hFFFF;
		pending.push_back(j);
		add_ticks(80, 90);
		stim_done = 1;
	end

	initial begin
		wait (stim_done && pending.size() == 0 && expected_views.size() == 0 && !in_valid);
		repeat (20) @(posedge clk);
		if (errors == 0) $display("i2c_register_access_master_tb: done, clean");
		else $display("i2c_register_access_master_tb: done, errors");
		$finish;
	end

	initial begin
		wait (cycles >= 400000);
		$display("i2c_register_access_master_tb: done, errors");
		$finish;
	end
endmodule
